// ===== src/orfs_pkg.sv =====
package orfs_pkg;

   // One input beat: a sequence character and the end-of-sequence mark.
   typedef struct packed {
      logic [7:0] base_char;
      logic       last_base;
   } req_payload_type;

   // One result beat.
   typedef struct packed {
      logic        report_kind;
      logic [31:0] start_pos;
      logic [31:0] stop_pos;
      logic [31:0] orf_length;
      logic [31:0] second_best_length;
      logic        orf_found;
      logic        last_result;
   } rsp_payload_type;

   localparam logic KIND_ORF     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [7:0] CHAR_A = 8'h61;
   localparam logic [7:0] CHAR_G = 8'h67;
   localparam logic [7:0] CHAR_T = 8'h74;

   localparam int unsigned NUM_FRAMES = 3;
   localparam int unsigned FRAME_W    = 2;

   localparam logic [FRAME_W-1:0] FRAME_0    = 2'd0;
   localparam logic [FRAME_W-1:0] FRAME_1    = 2'd1;
   localparam logic [FRAME_W-1:0] FRAME_LAST = 2'd2;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   localparam int unsigned CSR_W = 32;

endpackage

// ===== src/orfs_front.sv =====
module orfs_front #(
   parameter int unsigned POS_WIDTH = 32,
   parameter int unsigned ENTRY_W   = 3 * POS_WIDTH + 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  orfs_pkg::req_payload_type req_payload,
   output logic                     push_valid,
   input  logic                     push_ready,
   output logic [ENTRY_W-1:0]       push_data
);

   typedef struct packed {
      logic                        close;
      logic                        last;
      logic [orfs_pkg::FRAME_W-1:0] frame;
      logic [POS_WIDTH-1:0]        start;
      logic [POS_WIDTH-1:0]        stop;
      logic [POS_WIDTH-1:0]        len;
   } entry_type;

   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
   localparam logic [POS_WIDTH-1:0] POS_TWO = POS_WIDTH'(2);
   localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);

   logic [POS_WIDTH-1:0]         pos_ff, pos_in;
   logic [7:0]                   prior0_ff, prior0_in;
   logic [7:0]                   prior1_ff, prior1_in;
   // frame of the codon that completes with the current character
   logic [orfs_pkg::FRAME_W-1:0] phase_ff, phase_in;
   logic [orfs_pkg::NUM_FRAMES-1:0] open_valid_ff, open_valid_in;
   logic [POS_WIDTH-1:0]         open_start_ff [orfs_pkg::NUM_FRAMES];
   logic [POS_WIDTH-1:0]         open_start_in [orfs_pkg::NUM_FRAMES];

   logic [7:0]           ch;
   logic                 fire;
   logic                 codon_ok;
   logic                 is_start;
   logic                 is_stop;
   logic                 do_open;
   logic                 do_close;
   logic [POS_WIDTH-1:0] codon_pos;
   logic [POS_WIDTH-1:0] cur_start;
   entry_type            entry;

   assign ch        = req_payload.base_char;
   assign req_ready = push_ready;
   assign fire      = req_valid && push_ready;

   assign codon_ok  = (pos_ff >= POS_TWO) && (pos_ff != POS_MAX);
   assign codon_pos = pos_ff - POS_TWO;
   assign cur_start = open_start_ff[phase_ff];

   assign is_start = (prior0_ff == orfs_pkg::CHAR_A) && (prior1_ff == orfs_pkg::CHAR_T)
                     && (ch == orfs_pkg::CHAR_G);
   assign is_stop  = (prior0_ff == orfs_pkg::CHAR_T)
                     && (((prior1_ff == orfs_pkg::CHAR_A) && (ch == orfs_pkg::CHAR_G))
                      || ((prior1_ff == orfs_pkg::CHAR_A) && (ch == orfs_pkg::CHAR_A))
                      || ((prior1_ff == orfs_pkg::CHAR_G) && (ch == orfs_pkg::CHAR_A)));

   assign do_open  = codon_ok && !open_valid_ff[phase_ff] && is_start;
   assign do_close = codon_ok && open_valid_ff[phase_ff] && is_stop;

   always_comb begin
      entry.close = do_close;
      entry.last  = req_payload.last_base;
      entry.frame = phase_ff;
      entry.start = cur_start;
      entry.stop  = codon_pos;
      entry.len   = codon_pos - cur_start;
   end

   assign push_valid = req_valid && (do_close || req_payload.last_base);
   assign push_data  = entry;

   always_comb begin
      pos_in        = pos_ff;
      prior0_in     = prior0_ff;
      prior1_in     = prior1_ff;
      phase_in      = phase_ff;
      open_valid_in = open_valid_ff;
      open_start_in = open_start_ff;
      if (fire) begin
         if (req_payload.last_base) begin
            // end of sequence: back to the reset picture
            pos_in        = '0;
            prior0_in     = '0;
            prior1_in     = '0;
            phase_in      = orfs_pkg::FRAME_1;
            open_valid_in = '0;
         end else begin
            prior0_in = prior1_ff;
            prior1_in = ch;
            if (pos_ff != POS_MAX) begin
               pos_in   = pos_ff + POS_ONE;
               phase_in = (phase_ff == orfs_pkg::FRAME_LAST) ? orfs_pkg::FRAME_0
                          : phase_ff + 2'd1;
            end
            if (do_open) begin
               open_valid_in[phase_ff] = 1'b1;
               open_start_in[phase_ff] = codon_pos;
            end
            if (do_close) begin
               open_valid_in[phase_ff] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         prior0_ff     <= '0;
         prior1_ff     <= '0;
         phase_ff      <= orfs_pkg::FRAME_1;
         open_valid_ff <= '0;
      end else begin
         pos_ff        <= pos_in;
         prior0_ff     <= prior0_in;
         prior1_ff     <= prior1_in;
         phase_ff      <= phase_in;
         open_valid_ff <= open_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      open_start_ff <= open_start_in;
   end

endmodule

// ===== src/orfs_queue.sv =====
module orfs_queue #(
   parameter int unsigned WIDTH = 100
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam logic [orfs_pkg::QUEUE_PTR_W-1:0] PTR_ONE = orfs_pkg::QUEUE_PTR_W'(1);
   localparam logic [orfs_pkg::QUEUE_CNT_W-1:0] CNT_ONE = orfs_pkg::QUEUE_CNT_W'(1);

   logic [WIDTH-1:0]                 mem_ff [orfs_pkg::QUEUE_DEPTH];
   logic [orfs_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [orfs_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [orfs_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign push_ready = count_ff < orfs_pkg::QUEUE_CNT_W'(orfs_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_ONE : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_ONE : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/orfs_back.sv =====
module orfs_back #(
   parameter int unsigned POS_WIDTH = 32,
   parameter int unsigned ENTRY_W   = 3 * POS_WIDTH + 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [orfs_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  logic [ENTRY_W-1:0]            pop_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output orfs_pkg::rsp_payload_type     rsp_payload
);

   typedef struct packed {
      logic                        close;
      logic                        last;
      logic [orfs_pkg::FRAME_W-1:0] frame;
      logic [POS_WIDTH-1:0]        start;
      logic [POS_WIDTH-1:0]        stop;
      logic [POS_WIDTH-1:0]        len;
   } entry_type;

   localparam int unsigned CMP_W = (POS_WIDTH > orfs_pkg::CSR_W) ? POS_WIDTH : orfs_pkg::CSR_W;

   logic [orfs_pkg::CSR_W-1:0]   min_len_ff;
   logic [POS_WIDTH-1:0]         best_len_ff, best_len_in;
   logic [POS_WIDTH-1:0]         best_start_ff, best_start_in;
   logic [POS_WIDTH-1:0]         best_stop_ff, best_stop_in;
   logic [orfs_pkg::FRAME_W-1:0] best_frame_ff, best_frame_in;
   logic [POS_WIDTH-1:0]         runner_ff, runner_in;
   logic                         sum_pend_ff, sum_pend_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   orfs_pkg::rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   entry_type                    e;
   logic                         out_free;
   logic                         take;
   logic                         better;
   logic                         report;
   logic                         sum_now;
   logic [POS_WIDTH-1:0]         nxt_len, nxt_start, nxt_stop, nxt_runner;
   logic [orfs_pkg::FRAME_W-1:0] nxt_frame;

   assign e        = pop_data;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign take     = pop_valid && !sum_pend_ff && out_free;

   assign better = (e.len > best_len_ff)
                   || ((e.len == best_len_ff) && (best_len_ff != '0)
                       && (e.frame < best_frame_ff));

   assign report = take && e.close && (CMP_W'(e.len) > CMP_W'(min_len_ff));
   assign sum_now = (sum_pend_ff && out_free) || (take && e.last && !report);
   // hold the head while its summary still has to go out
   assign pop_ready = (sum_pend_ff && out_free) || (take && !(e.last && report));

   always_comb begin
      nxt_len    = best_len_ff;
      nxt_start  = best_start_ff;
      nxt_stop   = best_stop_ff;
      nxt_frame  = best_frame_ff;
      nxt_runner = runner_ff;
      if (take && e.close) begin
         if (better) begin
            nxt_runner = best_len_ff;
            nxt_len    = e.len;
            nxt_start  = e.start;
            nxt_stop   = e.stop;
            nxt_frame  = e.frame;
         end else if (e.len > runner_ff) begin
            nxt_runner = e.len;
         end
      end
   end

   always_comb begin
      if (sum_now) begin
         best_len_in   = '0;
         best_start_in = '0;
         best_stop_in  = '0;
         best_frame_in = orfs_pkg::FRAME_0;
         runner_in     = '0;
      end else begin
         best_len_in   = nxt_len;
         best_start_in = nxt_start;
         best_stop_in  = nxt_stop;
         best_frame_in = nxt_frame;
         runner_in     = nxt_runner;
      end
   end

   always_comb begin
      sum_pend_in = sum_pend_ff;
      if (sum_pend_ff && out_free) begin
         sum_pend_in = 1'b0;
      end else if (take && e.last && report) begin
         sum_pend_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in   = out_free ? (report || sum_now) : rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (report) begin
         rsp_payload_in.report_kind        = orfs_pkg::KIND_ORF;
         rsp_payload_in.start_pos          = 32'(e.start);
         rsp_payload_in.stop_pos           = 32'(e.stop);
         rsp_payload_in.orf_length         = 32'(e.len);
         rsp_payload_in.second_best_length = '0;
         rsp_payload_in.orf_found          = 1'b0;
         rsp_payload_in.last_result        = !e.last;
      end else if (sum_now) begin
         rsp_payload_in.report_kind        = orfs_pkg::KIND_SUMMARY;
         rsp_payload_in.start_pos          = 32'(nxt_start);
         rsp_payload_in.stop_pos           = 32'(nxt_stop);
         rsp_payload_in.orf_length         = 32'(nxt_len);
         rsp_payload_in.second_best_length = 32'(nxt_runner);
         rsp_payload_in.orf_found          = nxt_len != '0;
         rsp_payload_in.last_result        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff    <= '0;
         best_len_ff   <= '0;
         best_start_ff <= '0;
         best_stop_ff  <= '0;
         best_frame_ff <= orfs_pkg::FRAME_0;
         runner_ff     <= '0;
         sum_pend_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            min_len_ff <= csr_wdata;
         end
         best_len_ff   <= best_len_in;
         best_start_ff <= best_start_in;
         best_stop_ff  <= best_stop_in;
         best_frame_ff <= best_frame_in;
         runner_ff     <= runner_in;
         sum_pend_ff   <= sum_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== src/orf_scanner_three_frame_top.sv =====
// Three-frame ORF scanner. Feed one sequence character per req beat, with
// last_base set on the final character; character indices count from 0 and
// the codon ending at index i starts at i-2, in frame (i-2) mod 3. Each frame
// opens an ORF at the first lowercase atg and closes it at tag, taa or tga;
// a closed ORF longer than the csr_wdata threshold (min_orf_length, written
// while the block is idle) gives one rsp beat, and the last character gives a
// summary beat with the longest ORF (earlier frame, then earlier position,
// wins ties) and the second-best length, after which all state clears. The
// position counter saturates at 2^POS_WIDTH-1; characters at or beyond that
// index complete no codon. Throughput is one character per cycle while the
// queue has room; the front end classifies codons combinationally and pushes
// only ORF closes and ends of sequence into a four-beat queue, and the back
// end drains one queue beat per cycle into the rsp output register while
// that register is free, except that a beat which both reports an ORF and
// ends the sequence stays at the queue head until its summary goes out.
module orf_scanner_three_frame_top #(
   parameter int unsigned POS_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  orfs_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output orfs_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_we,
   input  logic [orfs_pkg::CSR_W-1:0] csr_wdata
);

   // queue beat: close, last, frame, start, stop, length
   localparam int unsigned ENTRY_W = 3 * POS_WIDTH + 2 + orfs_pkg::FRAME_W;

   logic               push_valid;
   logic               push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid;
   logic               pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   // front: track characters and open/close ORFs per frame
   orfs_front #(
      .POS_WIDTH (POS_WIDTH),
      .ENTRY_W   (ENTRY_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // decouple: lets the front keep taking characters while rsp stalls
   orfs_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: rank ORFs, apply the threshold, emit reports and summaries
   orfs_back #(
      .POS_WIDTH (POS_WIDTH),
      .ENTRY_W   (ENTRY_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== src/orfs_checker.sv =====
module orfs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input orfs_pkg::rsp_payload_type rsp_payload
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.report_kind == orfs_pkg::KIND_SUMMARY)
      |-> rsp_payload.last_result)
      else $error("summary beat without last_result");

   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.report_kind == orfs_pkg::KIND_ORF)
      |-> !rsp_payload.orf_found && (rsp_payload.second_best_length == '0))
      else $error("ORF report carries summary fields");

   a_report_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.report_kind == orfs_pkg::KIND_ORF)
      |-> rsp_payload.orf_length == 32'(rsp_payload.stop_pos - rsp_payload.start_pos))
      else $error("ORF report length mismatch");

endmodule

bind orf_scanner_three_frame_top orfs_checker u_orfs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== tb/sv/tb_orf_scanner_three_frame_top.sv =====
module tb_orf_scanner_three_frame_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Lowercase c is the only base the package does not name.
   localparam logic [7:0]  CHAR_C      = 8'h63;
   localparam logic [31:0] POS_LIMIT   = 32'hFFFF_FFFF;
   localparam int          CYCLE_LIMIT = 600000;
   localparam int          RANDOM_BEATS = 1000;
   localparam int          SETTLE_CYCLES = 8;

   // Start every input of the block at a known value.
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   orfs_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   orfs_pkg::rsp_payload_type rsp_payload;
   logic                      csr_we = 1'b0;
   logic [orfs_pkg::CSR_W-1:0] csr_wdata = '0;

   orf_scanner_three_frame_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Scanner state as the testbench tracks it. It advances once per
   // accepted req beat and queues the rsp beats that beat must cause.
   // ------------------------------------------------------------------
   logic [31:0]               char_count;
   logic [7:0]                prev_chars [2];
   logic [31:0]               open_start [3];
   logic                      open_flag [3];
   logic [31:0]               longest_len;
   logic [31:0]               longest_start;
   logic [31:0]               longest_stop;
   logic [1:0]                longest_frame;
   logic [31:0]               runner_up_len;
   logic [31:0]               min_orf_len = '0;
   orfs_pkg::rsp_payload_type expected_reports [$];

   // Run control shared by the test tasks and the two channel processes.
   bit req_gaps = 1'b0;
   bit rsp_gaps = 1'b0;
   int long_hold_left = 0;
   int error_count = 0;
   int cycle_count = 0;
   int beats_sent = 0;
   int sequences_sent = 0;
   int orf_reports_seen = 0;
   int summaries_seen = 0;

   function automatic void clear_scan();
      char_count    = '0;
      prev_chars    = '{default: '0};
      open_start    = '{default: '0};
      open_flag     = '{default: 1'b0};
      longest_len   = '0;
      longest_start = '0;
      longest_stop  = '0;
      longest_frame = '0;
      runner_up_len = '0;
   endfunction

   // Track one accepted character: the codon it completes, if any, can open or
   // close an ORF in its frame; the end mark adds a summary and clears state.
   task automatic scan_char(input logic [7:0] ch, input logic is_last);
      logic [31:0]               codon_pos;
      logic [31:0]               len;
      logic [1:0]                frame;
      logic                      has_orf;
      logic                      is_stop;
      orfs_pkg::rsp_payload_type orf_beat;
      orfs_pkg::rsp_payload_type summary_beat;

      has_orf  = 1'b0;
      orf_beat = '0;
      // A character at the saturated index completes no codon.
      if (char_count >= 2 && char_count != POS_LIMIT) begin
         codon_pos = char_count - 2;
         frame     = 2'(codon_pos % orfs_pkg::NUM_FRAMES);
         is_stop   = prev_chars[0] == orfs_pkg::CHAR_T &&
                     ((prev_chars[1] == orfs_pkg::CHAR_A &&
                       (ch == orfs_pkg::CHAR_G || ch == orfs_pkg::CHAR_A)) ||
                      (prev_chars[1] == orfs_pkg::CHAR_G && ch == orfs_pkg::CHAR_A));
         if (!open_flag[frame]) begin
            if (prev_chars[0] == orfs_pkg::CHAR_A && prev_chars[1] == orfs_pkg::CHAR_T &&
                ch == orfs_pkg::CHAR_G) begin
               open_flag[frame]  = 1'b1;
               open_start[frame] = codon_pos;
            end
         end else if (is_stop) begin
            len = codon_pos - open_start[frame];
            // Equal length: the earlier frame wins; same frame keeps the first.
            if (len > longest_len ||
                (len == longest_len && longest_len != 0 && frame < longest_frame)) begin
               runner_up_len = longest_len;
               longest_len   = len;
               longest_start = open_start[frame];
               longest_stop  = codon_pos;
               longest_frame = frame;
            end else if (len > runner_up_len) begin
               runner_up_len = len;
            end
            if (len > min_orf_len) begin
               has_orf              = 1'b1;
               orf_beat.report_kind = orfs_pkg::KIND_ORF;
               orf_beat.start_pos   = open_start[frame];
               orf_beat.stop_pos    = codon_pos;
               orf_beat.orf_length  = len;
            end
            open_flag[frame] = 1'b0;
         end
      end

      prev_chars[0] = prev_chars[1];
      prev_chars[1] = ch;
      if (char_count != POS_LIMIT) begin
         char_count = char_count + 1;
      end

      if (is_last) begin
         // An ORF still open here is dropped with the rest of the state.
         summary_beat                    = '0;
         summary_beat.report_kind        = orfs_pkg::KIND_SUMMARY;
         summary_beat.start_pos          = longest_start;
         summary_beat.stop_pos           = longest_stop;
         summary_beat.orf_length         = longest_len;
         summary_beat.second_best_length = runner_up_len;
         summary_beat.orf_found          = longest_len != 0;
         summary_beat.last_result        = 1'b1;
         if (has_orf) begin
            expected_reports = {expected_reports, orf_beat};
         end
         expected_reports = {expected_reports, summary_beat};
         clear_scan();
      end else if (has_orf) begin
         orf_beat.last_result = 1'b1;
         expected_reports = {expected_reports, orf_beat};
      end
   endtask

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------

   // Offer one character and hold it until the block takes it. A gap, when
   // one falls here, lowers valid first; otherwise valid stays high from the
   // previous beat so it never drops and rises in one step.
   task automatic send_base(input logic [7:0] ch, input logic is_last);
      if (req_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{base_char: ch, last_base: is_last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      scan_char(ch, is_last);
      beats_sent++;
      if (is_last) begin
         sequences_sent++;
      end
   endtask

   // Send a text as one whole sequence, end mark on its final character.
   task automatic send_text(input string txt);
      for (int i = 0; i < txt.len(); i++) begin
         send_base(txt[i], i == txt.len() - 1);
      end
   endtask

   // Build a sequence from codon-sized pieces so that starts and stops turn
   // up often in all three frames, with loose bases and raw noise mixed in.
   task automatic send_random_sequence(input int max_pieces);
      logic [7:0] seq [$];
      int         pieces;
      int         pick;

      pieces = $urandom_range(1, max_pieces);
      repeat (pieces) begin
         pick = $urandom_range(0, 19);
         if (pick < 5) begin
            seq = {seq, orfs_pkg::CHAR_A, orfs_pkg::CHAR_T, orfs_pkg::CHAR_G};
         end else if (pick < 9) begin
            seq = {seq, orfs_pkg::CHAR_T};
            case ($urandom_range(0, 2))
               0: begin
                  seq = {seq, orfs_pkg::CHAR_A, orfs_pkg::CHAR_G};
               end
               1: begin
                  seq = {seq, orfs_pkg::CHAR_A, orfs_pkg::CHAR_A};
               end
               default: begin
                  seq = {seq, orfs_pkg::CHAR_G, orfs_pkg::CHAR_A};
               end
            endcase
         end else if (pick < 18) begin
            case ($urandom_range(0, 3))
               0:       seq = {seq, orfs_pkg::CHAR_A};
               1:       seq = {seq, CHAR_C};
               2:       seq = {seq, orfs_pkg::CHAR_G};
               default: seq = {seq, orfs_pkg::CHAR_T};
            endcase
         end else begin
            seq = {seq, 8'($urandom_range(0, 255))};
         end
      end
      foreach (seq[i]) begin
         send_base(seq[i], i == seq.size() - 1);
      end
   endtask

   // Drop valid, wait for every expected report, then let any character
   // still inside the block that causes no report settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the threshold only once the block is idle.
   task automatic set_min_orf_length(input logic [31:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we      <= 1'b0;
      min_orf_len = value;
   endtask

   // ------------------------------------------------------------------
   // Receiver side: random stall bursts, plus a long hold-off on request
   // counted down here one cycle at a time.
   // ------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      if (long_hold_left > 0) begin
         rsp_ready <= 1'b0;
         long_hold_left--;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(1, 7) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each accepted rsp beat with the oldest expected report.
   always @(posedge clock) begin
      orfs_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected rsp beat: kind %0d start %0d stop %0d len %0d",
                   rsp_payload.report_kind, rsp_payload.start_pos,
                   rsp_payload.stop_pos, rsp_payload.orf_length);
            error_count++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_payload.report_kind == orfs_pkg::KIND_SUMMARY) begin
               summaries_seen++;
            end else begin
               orf_reports_seen++;
            end
            if (rsp_payload.report_kind !== want.report_kind) begin
               $error("report_kind: expected %0d, got %0d",
                      want.report_kind, rsp_payload.report_kind);
               error_count++;
            end
            if (rsp_payload.start_pos !== want.start_pos) begin
               $error("start_pos: expected %0d, got %0d",
                      want.start_pos, rsp_payload.start_pos);
               error_count++;
            end
            if (rsp_payload.stop_pos !== want.stop_pos) begin
               $error("stop_pos: expected %0d, got %0d",
                      want.stop_pos, rsp_payload.stop_pos);
               error_count++;
            end
            if (rsp_payload.orf_length !== want.orf_length) begin
               $error("orf_length: expected %0d, got %0d",
                      want.orf_length, rsp_payload.orf_length);
               error_count++;
            end
            if (rsp_payload.second_best_length !== want.second_best_length) begin
               $error("second_best_length: expected %0d, got %0d",
                      want.second_best_length, rsp_payload.second_best_length);
               error_count++;
            end
            if (rsp_payload.orf_found !== want.orf_found) begin
               $error("orf_found: expected %0d, got %0d",
                      want.orf_found, rsp_payload.orf_found);
               error_count++;
            end
            if (rsp_payload.last_result !== want.last_result) begin
               $error("last_result: expected %0d, got %0d",
                      want.last_result, rsp_payload.last_result);
               error_count++;
            end
         end
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, expected_reports.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hand-built sequences at the default threshold of zero.
   task automatic test_directed_cases();
      // Lone noise byte with the end mark: summary with nothing found.
      send_base(8'hFF, 1'b1);
      // ORF closes on the final character: report and summary from one beat.
      send_text("atgtga");
      // Equal-length ORFs, frame 1 first and frame 0 later: frame 0 must win
      // and the runner-up keeps the same length.
      send_text("catgtaatgtag");
      // Null byte, uppercase start that must not match, then an ORF left
      // open at the end that must be dropped.
      send_base(8'h00, 1'b0);
      send_text("ATGatg");
      drain();
   endtask

   // Walk the threshold through its extremes and a few points around the
   // short ORF lengths that the random sequences produce.
   task automatic test_threshold_sweep();
      logic [31:0] levels [7];

      levels = '{32'hFFFF_FFFF, 32'd0, 32'd2, 32'd3, 32'd9, 32'h8000_0000, 32'd1};
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      foreach (levels[i]) begin
         set_min_orf_length(levels[i]);
         repeat (6) send_random_sequence(20);
      end
      set_min_orf_length(32'd0);
   endtask

   // Hold the output off for a long stretch while short sequences that each
   // end with both a report and a summary keep coming: the internal queue
   // fills and req_ready must drop. Then pause until all reports are in.
   task automatic test_output_stall();
      req_gaps       = 1'b0;
      rsp_gaps       = 1'b0;
      long_hold_left = 150;
      repeat (25) send_text("atgtga");
      drain();
   endtask

   // Bulk random sequences in phases, each phase with its own threshold and
   // idling mix; the final phase runs with no idling at all.
   task automatic test_random_stream();
      int phase_target;

      phase_target = beats_sent;
      for (int phase = 0; phase < 8; phase++) begin
         set_min_orf_length(phase == 0 ? 32'd0 : 32'(3 * $urandom_range(0, 8)));
         req_gaps = (phase < 7) && ($urandom_range(0, 3) != 0);
         rsp_gaps = (phase < 7) && ($urandom_range(0, 3) != 0);
         phase_target += RANDOM_BEATS / 8;
         while (beats_sent < phase_target) begin
            // Mostly short sequences, now and then a long one.
            send_random_sequence($urandom_range(0, 9) == 0 ? 120 : 25);
         end
      end
      drain();
   endtask

   initial begin
      clear_scan();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_threshold_sweep();
      test_output_stall();
      test_random_stream();

      if (expected_reports.size() != 0) begin
         $error("%0d expected reports never arrived", expected_reports.size());
         error_count++;
      end
      $display("Scanned %0d characters in %0d sequences; checked %0d ORF reports",
               beats_sent, sequences_sent, orf_reports_seen);
      $display("and %0d summaries, thresholds 0 to all ones, stalls, hold-off and drains.",
               summaries_seen);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
